FILE: sv/continuity_scan_sequencer_macros.svh
// ----------------------------------------------------------------------------
// continuity scan sequencer assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CONTINUITY_SCAN_SEQUENCER_MACROS_SVH
`define CONTINUITY_SCAN_SEQUENCER_MACROS_SVH

// same-cycle implication
`define CSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/css_pkg.sv
// ----------------------------------------------------------------------------
// css_pkg
// types, codes and constants shared by the continuity scan sequencer
// ----------------------------------------------------------------------------
package css_pkg;

	localparam int MAX_LINES = 64;
	localparam int ROW_W     = 64;
	localparam int ROWS      = 64;
	localparam int ROW_AW    = 6;
	localparam int CNT_W     = 7;
	localparam int LINE_W    = 6;
	localparam int TIME_W    = 64;
	localparam int IVL_W     = 32;
	localparam int OP_W      = 3;
	localparam int APB_AW    = 4;
	localparam int APB_DW    = 32;

	// command codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_START    = 3'd1,
		OP_STOP     = 3'd2,
		OP_READ_ROW = 3'd3,
		OP_CLEAR    = 3'd4
	} op_e;

	// run status codes
	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_RUNNING = 2'd1,
		ST_DONE    = 2'd2
	} status_e;

	// register word indexes
	typedef enum logic [1:0] {
		REG_PIN_COUNT    = 2'd0,
		REG_TOTAL_CYCLES = 2'd1,
		REG_START_CYCLE  = 2'd2,
		REG_INTERVAL_US  = 2'd3
	} reg_e;

	typedef struct packed {
		logic [CNT_W-1:0]  pin_count;
		logic [CNT_W-1:0]  total_cycles;
		logic [LINE_W-1:0] start_cycle;
		logic [IVL_W-1:0]  interval_us;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		pin_count:    7'd64,
		total_cycles: 7'd64,
		start_cycle:  6'd0,
		interval_us:  32'd1000
	};

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [TIME_W-1:0] now_us;
		logic [ROW_W-1:0]  sense_bits;
		logic [ROW_AW-1:0] row_index;
	} cmd_t;

	// per-command result carried down the pipe
	typedef struct packed {
		logic              accepted;
		logic [1:0]        status;
		logic [CNT_W-1:0]  cycle_count;
		logic              fired;
		logic              drive_valid;
		logic [LINE_W-1:0] drive_line;
		logic              row_sel;
	} res_t;

	// row store access request
	typedef struct packed {
		logic              wr_en;
		logic [ROW_AW-1:0] wr_addr;
		logic [ROW_W-1:0]  wr_data;
		logic              rd_en;
		logic [ROW_AW-1:0] rd_addr;
		logic              clear;
	} store_req_t;

endpackage

FILE: sv/css_if.sv
// ----------------------------------------------------------------------------
// css_cmd_if / css_rsp_if
// command and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface css_cmd_if;
	import css_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [TIME_W-1:0] now_us;
	logic [ROW_W-1:0]  sense_bits;
	logic [ROW_AW-1:0] row_index;

	modport source (output valid, operation, now_us, sense_bits, row_index, input ready);
	modport sink (input valid, operation, now_us, sense_bits, row_index, output ready);
endinterface

interface css_rsp_if;
	import css_pkg::*;

	logic              valid;
	logic              ready;
	logic              accepted;
	logic [1:0]        status;
	logic [CNT_W-1:0]  cycle_count;
	logic              fired;
	logic              drive_valid;
	logic [LINE_W-1:0] drive_line;
	logic [ROW_W-1:0]  row_bits;

	modport source (output valid, accepted, status, cycle_count, fired, drive_valid,
		drive_line, row_bits, input ready);
	modport sink (input valid, accepted, status, cycle_count, fired, drive_valid,
		drive_line, row_bits, output ready);
endinterface

FILE: sv/css_cfg_regs.sv
// ----------------------------------------------------------------------------
// css_cfg_regs
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module css_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [css_pkg::APB_AW-1:0] paddr,
	input  logic [css_pkg::APB_DW-1:0] pwdata,
	output logic [css_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output css_pkg::cfg_t              cfg
);
	import css_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PIN_COUNT:    cfg_q.pin_count    <= pwdata[CNT_W-1:0];
				REG_TOTAL_CYCLES: cfg_q.total_cycles <= pwdata[CNT_W-1:0];
				REG_START_CYCLE:  cfg_q.start_cycle  <= pwdata[LINE_W-1:0];
				REG_INTERVAL_US:  cfg_q.interval_us  <= pwdata[IVL_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_PIN_COUNT:    prdata = APB_DW'(cfg_q.pin_count);
			REG_TOTAL_CYCLES: prdata = APB_DW'(cfg_q.total_cycles);
			REG_START_CYCLE:  prdata = APB_DW'(cfg_q.start_cycle);
			REG_INTERVAL_US:  prdata = APB_DW'(cfg_q.interval_us);
			default:          prdata = '0;
		endcase
	end

endmodule

FILE: sv/css_row_store.sv
// ----------------------------------------------------------------------------
// css_row_store
// 64 x 64 result row memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`include "continuity_scan_sequencer_macros.svh"

module css_row_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  css_pkg::store_req_t       req,
	output logic [css_pkg::ROW_W-1:0] rd_data
);
	import css_pkg::*;

	logic [ROW_W-1:0] mem [ROWS];
	logic [ROWS-1:0]  vld_q;
	logic [ROW_W-1:0] rd_q;
	logic             rd_vld_q;

	// memory array, write port and registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	// per-row written flags, cleared together by reset or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	// unwritten rows read as zero
	assign rd_data = rd_vld_q ? rd_q : '0;

	`CSS_ASSERT_IMPLY(a_clear_excl_wr, req.clear, !req.wr_en, "clear and row write together")
	`CSS_ASSERT_IMPLY(a_rd_excl_wr, req.rd_en, !req.wr_en && !req.clear, "read overlaps update")

endmodule

FILE: sv/css_ctrl.sv
// ----------------------------------------------------------------------------
// css_ctrl
// run state, scan timing and drive selection; issues row store accesses
// ----------------------------------------------------------------------------
`include "continuity_scan_sequencer_macros.svh"

module css_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  css_pkg::cfg_t       cfg,
	input  logic                cmd_fire,
	input  css_pkg::cmd_t       cmd,
	output css_pkg::res_t       res,
	output css_pkg::store_req_t store_req
);
	import css_pkg::*;

	status_e           run_status_q, run_status_d;
	logic [CNT_W-1:0]  cycle_cnt_q, cycle_cnt_d;
	logic [TIME_W-1:0] last_fire_q, last_fire_d;
	logic              act_valid_q, act_valid_d;
	logic [LINE_W-1:0] act_line_q, act_line_d;

	logic [CNT_W-1:0]  eff_pins, eff_total, cnt_inc;
	logic [TIME_W-1:0] elapsed;
	logic              due, in_win;
	logic [CNT_W:0]    win_hi;
	logic [LINE_W-1:0] line_off;
	logic [ROW_W-1:0]  line_mask;
	logic              accepted, fired, row_sel, wr_en, clear;

	// clamp the register values to the line count
	assign eff_pins  = (cfg.pin_count > CNT_W'(MAX_LINES)) ? CNT_W'(MAX_LINES) : cfg.pin_count;
	assign eff_total = (cfg.total_cycles > CNT_W'(MAX_LINES)) ?
		CNT_W'(MAX_LINES) : cfg.total_cycles;

	// interval check, first cycle of a run fires at once
	assign elapsed = cmd.now_us - last_fire_q;
	assign due     = (elapsed >= TIME_W'(cfg.interval_us)) || (cycle_cnt_q == '0);

	// drive window [start_cycle, start_cycle + pins)
	assign win_hi   = {2'b00, cfg.start_cycle} + {1'b0, eff_pins};
	assign in_win   = (cycle_cnt_q >= {1'b0, cfg.start_cycle}) &&
		({1'b0, cycle_cnt_q} < win_hi);
	assign line_off = cycle_cnt_q[LINE_W-1:0] - cfg.start_cycle;
	assign cnt_inc  = cycle_cnt_q + CNT_W'(1);
	assign line_mask = ~({ROW_W{1'b1}} << eff_pins);

	// command decode and next state
	always_comb begin
		run_status_d = run_status_q;
		cycle_cnt_d  = cycle_cnt_q;
		last_fire_d  = last_fire_q;
		act_valid_d  = act_valid_q;
		act_line_d   = act_line_q;
		accepted     = 1'b1;
		fired        = 1'b0;
		row_sel      = 1'b0;
		wr_en        = 1'b0;
		clear        = 1'b0;
		case (cmd.operation)
			OP_TICK: begin
				if (run_status_q == ST_RUNNING) begin
					if (cycle_cnt_q >= eff_total) begin
						run_status_d = ST_DONE;
						act_valid_d  = 1'b0;
						act_line_d   = '0;
					end else if (due) begin
						fired       = 1'b1;
						wr_en       = 1'b1;
						act_valid_d = in_win;
						act_line_d  = in_win ? line_off : '0;
						last_fire_d = cmd.now_us;
						cycle_cnt_d = cnt_inc;
						if (cnt_inc >= eff_total) begin
							run_status_d = ST_DONE;
							act_valid_d  = 1'b0;
							act_line_d   = '0;
						end
					end
				end
			end
			OP_START: begin
				if (run_status_q == ST_RUNNING || {1'b0, cfg.start_cycle} >= eff_total ||
					eff_pins == '0) begin
					accepted = 1'b0;
				end else begin
					run_status_d = ST_RUNNING;
					cycle_cnt_d  = '0;
					last_fire_d  = cmd.now_us;
					act_valid_d  = 1'b0;
					act_line_d   = '0;
				end
			end
			OP_STOP: begin
				if (run_status_q == ST_RUNNING) begin
					run_status_d = ST_IDLE;
					act_valid_d  = 1'b0;
					act_line_d   = '0;
				end
			end
			OP_READ_ROW: begin
				row_sel = ({1'b0, cmd.row_index} < eff_total);
			end
			OP_CLEAR: begin
				clear       = 1'b1;
				cycle_cnt_d = '0;
			end
			default: begin
				accepted = 1'b0;
			end
		endcase
	end

	// state update on each command transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_status_q <= ST_IDLE;
			cycle_cnt_q  <= '0;
			last_fire_q  <= '0;
			act_valid_q  <= 1'b0;
			act_line_q   <= '0;
		end else if (cmd_fire) begin
			run_status_q <= run_status_d;
			cycle_cnt_q  <= cycle_cnt_d;
			last_fire_q  <= last_fire_d;
			act_valid_q  <= act_valid_d;
			act_line_q   <= act_line_d;
		end
	end

	// row store requests
	always_comb begin
		store_req.wr_en   = cmd_fire && wr_en;
		store_req.wr_addr = cycle_cnt_q[ROW_AW-1:0];
		store_req.wr_data = cmd.sense_bits & line_mask;
		store_req.rd_en   = cmd_fire && (cmd.operation == OP_READ_ROW);
		store_req.rd_addr = cmd.row_index;
		store_req.clear   = cmd_fire && clear;
	end

	// result fields reflect the state after the command
	always_comb begin
		res.accepted    = accepted;
		res.status      = run_status_d;
		res.cycle_count = cycle_cnt_d;
		res.fired       = fired;
		res.drive_valid = act_valid_d;
		res.drive_line  = act_valid_d ? act_line_d : '0;
		res.row_sel     = row_sel;
	end

	`CSS_ASSERT_IMPLY(a_drive_only_running, act_valid_q, run_status_q == ST_RUNNING, "drive while not running")
	`CSS_ASSERT_IMPLY(a_cnt_bound, 1'b1, cycle_cnt_q <= CNT_W'(MAX_LINES), "cycle counter out of range")
	`CSS_ASSERT_NEXT(a_fire_counts, cmd_fire && fired, cycle_cnt_q == $past(cycle_cnt_q) + CNT_W'(1), "fire without count")

endmodule

FILE: sv/continuity_scan_sequencer.sv
// ----------------------------------------------------------------------------
// continuity_scan_sequencer
// wire-continuity scan sequencer top level
// ----------------------------------------------------------------------------
// Takes one command per clock (tick, start, stop, read row, clear) while the
// response channel does not stall, and returns one response per command, in
// order: the transfer updates the run state and issues the row memory access,
// stage 2 holds the result and the registered row read, and the response then
// sits in an output register while the next commands keep flowing. Sustained
// rate is one command per clock when responses are taken: each command updates
// the run state once and makes at most one access to the row memory (64 rows
// of 64 bits, one write port and one registered read port). Row written flags
// clear at reset and on clear, so no clearing pass is needed after reset.
// Configuration is to be written through the apb-style port only while no
// command is in flight; the block itself does not enforce this.
module continuity_scan_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	css_cmd_if.sink                    cmd,
	css_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [css_pkg::APB_AW-1:0] paddr,
	input  logic [css_pkg::APB_DW-1:0] pwdata,
	output logic [css_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import css_pkg::*;

	cfg_t             cfg;
	cmd_t             cmd_in;
	res_t             res;
	store_req_t       store_req;
	logic [ROW_W-1:0] rd_data;
	logic             cmd_fire;

	logic             valid_s2;
	res_t             res_s2;
	logic             adv_s2;
	logic             out_valid_q;
	res_t             out_res_q;
	logic [ROW_W-1:0] out_row_q;

	css_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// command payload
	always_comb begin
		cmd_in.operation  = cmd.operation;
		cmd_in.now_us     = cmd.now_us;
		cmd_in.sense_bits = cmd.sense_bits;
		cmd_in.row_index  = cmd.row_index;
	end

	// pipe handshake
	assign adv_s2    = valid_s2 && (!out_valid_q || rsp.ready);
	assign cmd.ready = !valid_s2 || adv_s2;
	assign cmd_fire  = cmd.valid && cmd.ready;

	css_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_fire  (cmd_fire),
		.cmd       (cmd_in),
		.res       (res),
		.store_req (store_req)
	);

	css_row_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (store_req),
		.rd_data (rd_data)
	);

	// stage 2: waits for the row read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (cmd_fire) begin
			valid_s2 <= 1'b1;
		end else if (adv_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			res_s2 <= res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			out_res_q <= res_s2;
			out_row_q <= res_s2.row_sel ? rd_data : '0;
		end
	end

	// response channel
	assign rsp.valid       = out_valid_q;
	assign rsp.accepted    = out_res_q.accepted;
	assign rsp.status      = out_res_q.status;
	assign rsp.cycle_count = out_res_q.cycle_count;
	assign rsp.fired       = out_res_q.fired;
	assign rsp.drive_valid = out_res_q.drive_valid;
	assign rsp.drive_line  = out_res_q.drive_line;
	assign rsp.row_bits    = out_row_q;

endmodule
